>>> src/mct_pkg.sv
// ---------------------------------------------------------------------------
// mct_pkg
// Shared types and codes of the majority commit tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package mct_pkg;

    localparam int unsigned IDX_W     = 32;
    localparam int unsigned S_DATA_W  = 72;
    localparam int unsigned S_USER_W  = 2;
    localparam int unsigned M_DATA_W  = 104;
    localparam int unsigned CFG_W     = 4;

    localparam logic [IDX_W-1:0] HEAD_LIMIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_ACK    = 2'd1,
        OP_LEAD   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_LEADER = 2'd1,
        ST_BAD_PEER   = 2'd2,
        ST_FULL       = 2'd3
    } status_t;

    typedef enum logic {
        CFG_NODE_COUNT  = 1'b0,
        CFG_LOCAL_INDEX = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] tag;
        logic [IDX_W-1:0] term;
    } slot_t;

endpackage

`default_nettype wire

>>> src/mct_cmp.sv
// ---------------------------------------------------------------------------
// mct_cmp
// Shared magnitude comparator used by the update, scan and commit steps of the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module mct_cmp
    import mct_pkg::*;
(
    input  wire logic [IDX_W-1:0] a,
    input  wire logic [IDX_W-1:0] b,
    output logic                  gt
);

    assign gt = (a > b);

endmodule

`default_nettype wire

>>> src/mct_mod.sv
// ---------------------------------------------------------------------------
// mct_mod
// Log index to ring slot reduction; mask for a power-of-two depth, otherwise
// a reciprocal multiply, a back-multiply and one correcting subtract.
// ---------------------------------------------------------------------------
`default_nettype none

module mct_mod
    import mct_pkg::*;
#(
    parameter int unsigned DEPTH = 4096
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [IDX_W-1:0]         value,
    output logic                          done,
    output logic [$clog2(DEPTH)-1:0]      rem
);

    localparam int unsigned AW   = $clog2(DEPTH);
    localparam bit          POW2 = ((DEPTH & (DEPTH - 1)) == 0);

    generate
        if (POW2) begin : g_mask
            logic [AW-1:0] rem_reg;
            logic          done_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= value[AW-1:0];
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
        else begin : g_recip
            localparam logic [IDX_W-1:0] DIVISOR = IDX_W'(DEPTH);
            localparam logic [IDX_W-1:0] RECIP   = IDX_W'((64'd1 << IDX_W) / 64'(DEPTH));

            logic [2*IDX_W-1:0] prod_reg;
            logic [IDX_W-1:0]   value_reg;
            logic [IDX_W-1:0]   est_reg;
            logic [AW-1:0]      rem_reg;
            logic [1:0]         stage_reg;
            logic               done_reg;
            logic [IDX_W-1:0]   quot;
            logic [IDX_W-1:0]   est;

            // quotient estimate is exact or one low, so est stays below 2*DEPTH
            always_comb
            begin
                quot = prod_reg[2*IDX_W-1:IDX_W];
                est  = value_reg - (quot * DIVISOR);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_reg <= '0;
                    done_reg  <= 1'b0;
                end
                else
                begin
                    stage_reg <= {stage_reg[0], start};
                    done_reg  <= stage_reg[1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    prod_reg  <= (2*IDX_W)'(value) * (2*IDX_W)'(RECIP);
                    value_reg <= value;
                end
                if (stage_reg[0])
                begin
                    est_reg <= est;
                end
                if (stage_reg[1])
                begin
                    rem_reg <= AW'((est_reg >= DIVISOR) ? (est_reg - DIVISOR) : est_reg);
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
    endgenerate

endmodule

`default_nettype wire

>>> src/mct_ring.sv
// ---------------------------------------------------------------------------
// mct_ring
// Tagged term ring with a registered read port and a clearing sweep after
// reset.
// ---------------------------------------------------------------------------
`default_nettype none

module mct_ring
    import mct_pkg::*;
#(
    parameter int unsigned DEPTH = 4096
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire slot_t                    wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output slot_t                         rd_data,
    output logic                          busy
);

    localparam int unsigned AW = $clog2(DEPTH);

    slot_t         mem [DEPTH];
    slot_t         rd_data_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

>>> src/majority_commit_tracker.sv
// ---------------------------------------------------------------------------
// majority_commit_tracker
// Raft leader commit bookkeeping: log index assignment, peer match tracking
// and majority commit advance.
// Append, become-leader and rejected acks go straight to the result; an accepted
// ack makes k = n/2 + 1 selection passes over the match indexes and the last
// log index through one shared comparator, with n the node count, then reduces
// the candidate to a ring slot (mask for a power-of-two LOG_DEPTH, reciprocal
// remainder otherwise); that step is skipped when the candidate does not pass
// the commit index, and an ack on an empty log skips the selection.
// One item in flight at a time.
// Reset: commit 0, head 1, matches 0; then a clearing pass over every slot
// of the term ring holds s_tready low.
// ---------------------------------------------------------------------------
`default_nettype none

module majority_commit_tracker
    import mct_pkg::*;
#(
    parameter int unsigned MAX_NODES = 8,
    parameter int unsigned LOG_DEPTH = 4096
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // peer_idx, acked_index, current_term, is_leader
    input  wire logic [S_USER_W-1:0] s_tuser,   // operation
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // status, assigned_index, commit_idx,
                                                // peer_next_index
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    localparam int unsigned AW = $clog2(LOG_DEPTH);
    localparam int unsigned EW = $clog2(MAX_NODES + 1);
    localparam int unsigned IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_UPD  = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_CMT  = 7'b0001000,
        S_MOD  = 7'b0010000,
        S_CHK  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [3:0]          node_count_reg;
    logic [2:0]          local_reg;
    logic [IDX_W-1:0]    match_reg [MAX_NODES];
    logic [IDX_W-1:0]    commit_reg, commit_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [AW-1:0]       head_slot_reg, head_slot_next;
    logic [2:0]          peer_reg, peer_next;
    logic [IDX_W-1:0]    acked_reg, acked_next;
    logic [IDX_W-1:0]    term_reg, term_next;
    status_t             res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_assigned_reg, res_assigned_next;
    logic [IDX_W-1:0]    res_next_reg, res_next_next;
    logic [EW-1:0]       walk_reg, walk_next;
    logic [EW-1:0]       pass_reg, pass_next;
    logic [MAX_NODES:0]  taken_reg, taken_next;
    logic [IDX_W-1:0]    best_reg, best_next;
    logic [EW-1:0]       best_idx_reg, best_idx_next;
    logic                best_valid_reg, best_valid_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                accept;
    logic [2:0]          in_peer;
    logic [IDX_W-1:0]    in_acked;
    logic [IDX_W-1:0]    in_term;
    logic                in_lead;
    logic [EW-1:0]       eff_n;
    logic [EW-1:0]       k_val;
    logic [IDX_W-1:0]    last_idx;
    logic                bad_peer;
    logic [IW-1:0]       rd_idx;
    logic [IDX_W-1:0]    match_rd;
    logic                match_we;
    logic                match_clr;
    logic                is_lead;
    logic                included;
    logic                take;
    logic [IDX_W-1:0]    scan_val;
    logic [EW-1:0]       pick_idx;
    logic [IDX_W-1:0]    cmp_a, cmp_b;
    logic                cmp_gt;
    logic                mod_start, mod_done;
    logic [AW-1:0]       mod_rem;
    logic                ring_wr_en, ring_rd_en, ring_busy;
    slot_t               ring_wr_data, ring_rd_data;

    assign in_peer  = s_tdata[2:0];
    assign in_acked = s_tdata[34:3];
    assign in_term  = s_tdata[66:35];
    assign in_lead  = s_tdata[67];

    assign s_tready = (state_reg == S_IDLE) && !ring_busy;
    assign accept   = s_tvalid && s_tready;
    assign last_idx = head_reg - 32'd1;

    always_comb
    begin
        if (node_count_reg == 4'd0)
        begin
            eff_n = EW'(1);
        end
        else if (32'(node_count_reg) > MAX_NODES)
        begin
            eff_n = EW'(MAX_NODES);
        end
        else
        begin
            eff_n = EW'(node_count_reg);
        end
        k_val    = (eff_n >> 1) + EW'(1);
        bad_peer = (32'(in_peer) >= 32'(eff_n)) || (32'(in_peer) >= MAX_NODES) ||
                   (in_peer == local_reg);
    end

    assign rd_idx   = (state_reg == S_UPD) ? IW'(32'(peer_reg)) : walk_reg[IW-1:0];
    assign match_rd = match_reg[rd_idx];

    assign is_lead  = (walk_reg == eff_n);
    assign included = is_lead || ((walk_reg < eff_n) && (32'(walk_reg) != 32'(local_reg)));
    assign scan_val = is_lead ? last_idx : match_rd;

    always_comb
    begin
        unique case (state_reg)
            S_UPD:
            begin
                cmp_a = acked_reg;
                cmp_b = match_rd;
            end
            S_SCAN:
            begin
                cmp_a = scan_val;
                cmp_b = best_reg;
            end
            default:
            begin
                cmp_a = best_reg;
                cmp_b = commit_reg;
            end
        endcase
    end

    mct_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .gt (cmp_gt)
    );

    assign take      = included && !taken_reg[walk_reg] && (!best_valid_reg || cmp_gt);
    assign pick_idx  = take ? walk_reg : best_idx_reg;
    assign mod_start = (state_reg == S_CMT) && cmp_gt;

    mct_mod #(
        .DEPTH (LOG_DEPTH)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (best_reg),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    assign ring_wr_en   = accept && (s_tuser == OP_APPEND) && (head_reg != HEAD_LIMIT);
    assign ring_wr_data = '{valid: 1'b1, tag: head_reg, term: in_term};
    assign ring_rd_en   = (state_reg == S_MOD) && mod_done;

    mct_ring #(
        .DEPTH (LOG_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ring_wr_en),
        .wr_addr (head_slot_reg),
        .wr_data (ring_wr_data),
        .rd_en   (ring_rd_en),
        .rd_addr (mod_rem),
        .rd_data (ring_rd_data),
        .busy    (ring_busy)
    );

    always_comb
    begin
        state_next        = state_reg;
        commit_next       = commit_reg;
        head_next         = head_reg;
        head_slot_next    = head_slot_reg;
        peer_next         = peer_reg;
        acked_next        = acked_reg;
        term_next         = term_reg;
        res_status_next   = res_status_reg;
        res_assigned_next = res_assigned_reg;
        res_next_next     = res_next_reg;
        walk_next         = walk_reg;
        pass_next         = pass_reg;
        taken_next        = taken_reg;
        best_next         = best_reg;
        best_idx_next     = best_idx_reg;
        best_valid_next   = best_valid_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        match_we          = 1'b0;
        match_clr         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next   = ST_OK;
                    res_assigned_next = '0;
                    res_next_next     = '0;
                    peer_next         = in_peer;
                    acked_next        = in_acked;
                    term_next         = in_term;
                    state_next        = S_OUT;
                    unique case (s_tuser)
                        OP_APPEND:
                        begin
                            if (head_reg == HEAD_LIMIT)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                res_assigned_next = head_reg;
                                head_next         = head_reg + 32'd1;
                                head_slot_next    = (head_slot_reg == AW'(LOG_DEPTH - 1)) ?
                                                    '0 : head_slot_reg + AW'(1);
                            end
                        end
                        OP_ACK:
                        begin
                            if (!in_lead)
                            begin
                                res_status_next = ST_NOT_LEADER;
                            end
                            else if (bad_peer)
                            begin
                                res_status_next = ST_BAD_PEER;
                            end
                            else
                            begin
                                res_next_next = (in_acked == HEAD_LIMIT) ?
                                                in_acked : in_acked + 32'd1;
                                state_next    = S_UPD;
                            end
                        end
                        OP_LEAD:
                        begin
                            match_clr = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UPD:
            begin
                match_we        = cmp_gt;
                walk_next       = '0;
                pass_next       = '0;
                taken_next      = '0;
                best_valid_next = 1'b0;
                state_next      = (head_reg == 32'd1) ? S_OUT : S_SCAN;
            end
            S_SCAN:
            begin
                if (take)
                begin
                    best_next       = scan_val;
                    best_idx_next   = walk_reg;
                    best_valid_next = 1'b1;
                end
                if (is_lead)
                begin
                    taken_next[pick_idx] = 1'b1;
                    pass_next            = pass_reg + EW'(1);
                    walk_next            = '0;
                    best_valid_next      = 1'b0;
                    if (pass_reg + EW'(1) == k_val)
                    begin
                        state_next = S_CMT;
                    end
                end
                else
                begin
                    walk_next = walk_reg + EW'(1);
                end
            end
            S_CMT:
            begin
                state_next = cmp_gt ? S_MOD : S_OUT;
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (ring_rd_data.valid && (ring_rd_data.tag == best_reg) &&
                    (ring_rd_data.term == term_reg))
                begin
                    commit_next = best_reg;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, res_next_reg, commit_reg, res_assigned_reg,
                                     res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= 4'd3;
            local_reg      <= 3'd0;
            commit_reg     <= '0;
            head_reg       <= 32'd1;
            head_slot_reg  <= AW'(1);
            m_tvalid_reg   <= 1'b0;
            walk_reg       <= '0;
            pass_reg       <= '0;
            taken_reg      <= '0;
            best_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_NODES; i++)
            begin
                match_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            commit_reg     <= commit_next;
            head_reg       <= head_next;
            head_slot_reg  <= head_slot_next;
            m_tvalid_reg   <= m_tvalid_next;
            walk_reg       <= walk_next;
            pass_reg       <= pass_next;
            taken_reg      <= taken_next;
            best_valid_reg <= best_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NODE_COUNT:  node_count_reg <= cfg_data;
                    CFG_LOCAL_INDEX: local_reg      <= cfg_data[2:0];
                endcase
            end
            if (match_clr)
            begin
                for (int i = 0; i < MAX_NODES; i++)
                begin
                    match_reg[i] <= '0;
                end
            end
            else if (match_we)
            begin
                match_reg[rd_idx] <= acked_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        peer_reg         <= peer_next;
        acked_reg        <= acked_next;
        term_reg         <= term_next;
        res_status_reg   <= res_status_next;
        res_assigned_reg <= res_assigned_next;
        res_next_reg     <= res_next_next;
        best_reg         <= best_next;
        best_idx_reg     <= best_idx_next;
        m_tdata_reg      <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        ring_busy |-> !s_tready)
        else $error("input accepted during ring clearing pass");

    a_commit_below_head: assert property (@(posedge clk) disable iff (!rst_n)
        commit_reg < head_reg)
        else $error("commit index reached beyond the log head");

    a_commit_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> commit_reg >= $past(commit_reg))
        else $error("commit index moved backward");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (pass_reg < k_val))
        else $error("selection ran past the majority rank");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the majority commit tracker. A short table of
// directed transactions runs first, then randomized leader sessions
// (become-leader, appends, peer acks) mixed with noise, under several cluster
// settings and backpressure mixes. Every result is compared field by field
// with a typed row's reply or an in-bench model of head, matches and commit.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import mct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PEERS_MAX  = 8;
    localparam int unsigned RING_DEPTH = 4096;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam int          NUM_PHASES = 7;
    localparam int          PHASE_ITEMS = 72;
    localparam int          SETTLE_CYCLES = 60;

    typedef struct {
        logic [1:0]  op;
        logic [2:0]  peer;
        logic [31:0] acked;
        logic [31:0] term;
        logic        leader;
    } cmd_t;

    typedef struct {
        status_t     st;
        logic [31:0] asg;
        logic [31:0] cmt;
        logic [31:0] nxt;
    } reply_t;

    typedef struct {
        cmd_t   cmd;
        bit     typed;
        reply_t rep;
    } dir_row_t;

    logic                clk = 1'b1;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // peer_idx, acked_index, current_term, is_leader
    logic [S_USER_W-1:0] s_tuser = '0;   // operation
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // status, assigned_index, commit_idx,
                                         // peer_next_index
    logic                cfg_we = 1'b0;
    logic                cfg_index = CFG_NODE_COUNT;
    logic [CFG_W-1:0]    cfg_data = '0;

    reply_t      pending_replies[$];
    int          err_cnt = 0;
    int          tx_idle_pct = 31;
    int          rx_idle_pct = 69;

    int unsigned mdl_nodes = 3;
    int unsigned mdl_local = 0;
    logic [31:0] mdl_match[PEERS_MAX];
    logic [31:0] mdl_next[PEERS_MAX];
    logic [31:0] mdl_commit = '0;
    logic [31:0] mdl_head = 32'd1;
    bit          ring_ok[RING_DEPTH];
    logic [31:0] ring_tag[RING_DEPTH];
    logic [31:0] ring_term[RING_DEPTH];
    logic [31:0] session_term = 32'd1;

    dir_row_t    dir_tab[20];
    int          cfg_n_tab[NUM_PHASES] = '{3, 8, 1, 0, 15, 4, 2};
    int          cfg_l_tab[NUM_PHASES] = '{1, 7, 0, 5, 3, 7, 1};

    majority_commit_tracker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic int unsigned active_nodes();
        if (mdl_nodes == 0)
            return 1;
        if (mdl_nodes > PEERS_MAX)
            return PEERS_MAX;
        return mdl_nodes;
    endfunction

    function automatic reply_t commit_model_step(cmd_t c);
        reply_t      r;
        int unsigned n;
        int unsigned cnt;
        int unsigned slot;
        int          i;
        int          j;
        logic [31:0] vals[PEERS_MAX + 1];
        logic [31:0] v;
        logic [31:0] cand;
        r = '{ST_OK, 32'd0, 32'd0, 32'd0};
        n = active_nodes();
        case (c.op)
            OP_APPEND:
            begin
                if (mdl_head == HEAD_LIMIT)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    slot = mdl_head % RING_DEPTH;
                    ring_ok[slot] = 1'b1;
                    ring_tag[slot] = mdl_head;
                    ring_term[slot] = c.term;
                    r.asg = mdl_head;
                    mdl_head = mdl_head + 1;
                end
            end
            OP_ACK:
            begin
                if (!c.leader)
                begin
                    r.st = ST_NOT_LEADER;
                end
                else if (c.peer >= n || c.peer == mdl_local)
                begin
                    r.st = ST_BAD_PEER;
                end
                else
                begin
                    if (c.acked > mdl_match[c.peer])
                        mdl_match[c.peer] = c.acked;
                    mdl_next[c.peer] = (c.acked == HEAD_LIMIT) ? c.acked : c.acked + 1;
                    r.nxt = mdl_next[c.peer];
                    if (mdl_head - 1 != 0)
                    begin
                        cnt = 0;
                        vals[cnt] = mdl_head - 1;
                        cnt++;
                        for (i = 0; i < n; i++)
                        begin
                            if (i != mdl_local)
                            begin
                                vals[cnt] = mdl_match[i];
                                cnt++;
                            end
                        end
                        for (i = 1; i < cnt; i++)
                        begin
                            v = vals[i];
                            j = i;
                            while (j > 0 && vals[j - 1] > v)
                            begin
                                vals[j] = vals[j - 1];
                                j--;
                            end
                            vals[j] = v;
                        end
                        cand = vals[cnt - (n / 2 + 1)];
                        slot = cand % RING_DEPTH;
                        if (cand > mdl_commit && ring_ok[slot] && ring_tag[slot] == cand
                            && ring_term[slot] == c.term)
                            mdl_commit = cand;
                    end
                end
            end
            OP_LEAD:
            begin
                for (i = 0; i < PEERS_MAX; i++)
                begin
                    mdl_match[i] = '0;
                    mdl_next[i] = mdl_head;
                end
            end
            default:
            begin
            end
        endcase
        r.cmt = mdl_commit;
        return r;
    endfunction

    always @(posedge clk)
    begin
        reply_t           exp_r;
        logic [1:0]       got_st;
        logic [31:0]      got_asg;
        logic [31:0]      got_cmt;
        logic [31:0]      got_nxt;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_st  = m_tdata[1:0];
            got_asg = m_tdata[33:2];
            got_cmt = m_tdata[65:34];
            got_nxt = m_tdata[97:66];
            if (pending_replies.size() == 0)
            begin
                $error("unexpected result transaction: status %0d commit %0d",
                       got_st, got_cmt);
                err_cnt++;
            end
            else
            begin
                exp_r = pending_replies.pop_front();
                if (got_st != exp_r.st)
                begin
                    $error("status: expected %0d, got %0d", exp_r.st, got_st);
                    err_cnt++;
                end
                if (got_asg != exp_r.asg)
                begin
                    $error("assigned_index: expected %0d, got %0d", exp_r.asg, got_asg);
                    err_cnt++;
                end
                if (got_cmt != exp_r.cmt)
                begin
                    $error("commit_idx: expected %0d, got %0d", exp_r.cmt, got_cmt);
                    err_cnt++;
                end
                if (got_nxt != exp_r.nxt)
                begin
                    $error("peer_next_index: expected %0d, got %0d", exp_r.nxt, got_nxt);
                    err_cnt++;
                end
            end
        end
    end

    // Enter and leave at a falling edge.
    task automatic send_cmd(input cmd_t c, input bit typed, input reply_t typed_rep);
        reply_t r;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, c.leader, c.term, c.acked, c.peer};
        s_tuser  <= c.op;
        do
            @(posedge clk);
        while (!s_tready);
        r = commit_model_step(c);
        pending_replies.push_back(typed ? typed_rep : r);
        @(negedge clk);
    endtask

    task automatic send_checked(input cmd_t c);
        send_cmd(c, 1'b0, '{ST_OK, 32'd0, 32'd0, 32'd0});
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_replies.size() != 0);
    endtask

    task automatic write_cluster_cfg(input int unsigned nodes, input int unsigned local_idx);
        drain_replies();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NODE_COUNT;
        cfg_data  <= nodes[CFG_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_LOCAL_INDEX;
        cfg_data  <= {1'b0, local_idx[2:0]};
        @(negedge clk);
        cfg_we    <= 1'b0;
        mdl_nodes = nodes;
        mdl_local = local_idx;
    endtask

    function automatic logic [2:0] pick_peer();
        int unsigned n;
        logic [2:0]  p;
        n = active_nodes();
        p = 3'($urandom_range(n - 1));
        repeat (8)
        begin
            if (p != mdl_local || n == 1)
                break;
            p = 3'($urandom_range(n - 1));
        end
        return p;
    endfunction

    function automatic logic [31:0] pick_ack_index();
        case ($urandom_range(9))
            0: return HEAD_LIMIT;
            1: return mdl_head - 1 + RING_DEPTH;
            2: return 32'd0;
            default: return $urandom_range(mdl_head - 1, mdl_commit);
        endcase
    endfunction

    task automatic run_sessions(input int n_items);
        cmd_t c;
        int   sent;
        int   k;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(49) == 0)
                drain_replies();
            if ($urandom_range(99) < 70)
            begin
                if ($urandom_range(3) == 0)
                begin
                    session_term = $urandom;
                    c = '{OP_LEAD, 3'($urandom), $urandom, $urandom, 1'($urandom)};
                    send_checked(c);
                    sent++;
                end
                k = $urandom_range(1, 4);
                repeat (k)
                begin
                    c = '{OP_APPEND, 3'($urandom), $urandom, session_term, 1'($urandom)};
                    send_checked(c);
                    sent++;
                end
                k = $urandom_range(2, 6);
                repeat (k)
                begin
                    c.op     = OP_ACK;
                    c.peer   = pick_peer();
                    c.acked  = pick_ack_index();
                    c.term   = ($urandom_range(7) == 0) ? $urandom : session_term;
                    c.leader = 1'b1;
                    send_checked(c);
                    sent++;
                end
            end
            else
            begin
                c = '{2'($urandom), 3'($urandom), $urandom, $urandom, 1'($urandom)};
                send_checked(c);
                sent++;
            end
        end
    endtask

    initial
    begin
        dir_tab[0]  = '{'{OP_ACK, 3'd1, 32'd0, 32'd5, 1'b1}, 1'b1,
                        '{ST_OK, 32'd0, 32'd0, 32'd1}};
        dir_tab[1]  = '{'{OP_ACK, 3'd1, 32'd7, 32'd5, 1'b0}, 1'b1,
                        '{ST_NOT_LEADER, 32'd0, 32'd0, 32'd0}};
        dir_tab[2]  = '{'{OP_ACK, 3'd0, 32'd7, 32'd5, 1'b1}, 1'b1,
                        '{ST_BAD_PEER, 32'd0, 32'd0, 32'd0}};
        dir_tab[3]  = '{'{OP_ACK, 3'd3, 32'd7, 32'd5, 1'b1}, 1'b1,
                        '{ST_BAD_PEER, 32'd0, 32'd0, 32'd0}};
        dir_tab[4]  = '{'{OP_ACK, 3'd7, 32'd7, 32'd5, 1'b1}, 1'b1,
                        '{ST_BAD_PEER, 32'd0, 32'd0, 32'd0}};
        dir_tab[5]  = '{'{OP_UNUSED, 3'd5, HEAD_LIMIT, HEAD_LIMIT, 1'b1}, 1'b1,
                        '{ST_OK, 32'd0, 32'd0, 32'd0}};
        dir_tab[6]  = '{'{OP_LEAD, 3'd0, 32'd0, 32'd0, 1'b0}, 1'b1,
                        '{ST_OK, 32'd0, 32'd0, 32'd0}};
        dir_tab[7]  = '{'{OP_APPEND, 3'd0, 32'd0, 32'd5, 1'b0}, 1'b1,
                        '{ST_OK, 32'd1, 32'd0, 32'd0}};
        dir_tab[8]  = '{'{OP_APPEND, 3'd7, HEAD_LIMIT, 32'd5, 1'b1}, 1'b1,
                        '{ST_OK, 32'd2, 32'd0, 32'd0}};
        dir_tab[9]  = '{'{OP_APPEND, 3'd0, 32'd0, HEAD_LIMIT, 1'b1}, 1'b1,
                        '{ST_OK, 32'd3, 32'd0, 32'd0}};
        dir_tab[10] = '{'{OP_ACK, 3'd1, 32'd2, 32'd5, 1'b1}, 1'b0,
                        '{ST_OK, 32'd0, 32'd0, 32'd0}};
        dir_tab[11] = '{'{OP_ACK, 3'd2, 32'd3, 32'd5, 1'b1}, 1'b0,
                        '{ST_OK, 32'd0, 32'd0, 32'd0}};
        dir_tab[12] = '{'{OP_ACK, 3'd2, 32'd3, HEAD_LIMIT, 1'b1}, 1'b0,
                        '{ST_OK, 32'd0, 32'd0, 32'd0}};
        dir_tab[13] = '{'{OP_ACK, 3'd1, 32'd1, 32'd0, 1'b1}, 1'b0,
                        '{ST_OK, 32'd0, 32'd0, 32'd0}};
        dir_tab[14] = '{'{OP_ACK, 3'd1, HEAD_LIMIT, 32'd0, 1'b1}, 1'b1,
                        '{ST_OK, 32'd0, 32'd3, HEAD_LIMIT}};
        dir_tab[15] = '{'{OP_ACK, 3'd2, HEAD_LIMIT, 32'd0, 1'b1}, 1'b0,
                        '{ST_OK, 32'd0, 32'd0, 32'd0}};
        dir_tab[16] = '{'{OP_LEAD, 3'd3, 32'd0, 32'd0, 1'b0}, 1'b0,
                        '{ST_OK, 32'd0, 32'd0, 32'd0}};
        dir_tab[17] = '{'{OP_APPEND, 3'd0, 32'd0, 32'd9, 1'b1}, 1'b1,
                        '{ST_OK, 32'd4, 32'd3, 32'd0}};
        // Two peers ahead by a full ring: candidate slot holds another index.
        dir_tab[18] = '{'{OP_ACK, 3'd1, 32'd4100, 32'd9, 1'b1}, 1'b0,
                        '{ST_OK, 32'd0, 32'd0, 32'd0}};
        dir_tab[19] = '{'{OP_ACK, 3'd2, 32'd4100, 32'd9, 1'b1}, 1'b0,
                        '{ST_OK, 32'd0, 32'd0, 32'd0}};

        for (int i = 0; i < PEERS_MAX; i++)
        begin
            mdl_match[i] = '0;
            mdl_next[i] = '0;
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].rep);
        drain_replies();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_cluster_cfg(cfg_n_tab[p], cfg_l_tab[p]);
            if (p < 2)
            begin
                tx_idle_pct = 31;
                rx_idle_pct = 69;
            end
            else if (p < 4)
            begin
                tx_idle_pct = 69;
                rx_idle_pct = 31;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            run_sessions(PHASE_ITEMS);
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
src/mct_pkg.sv
src/mct_cmp.sv
src/mct_mod.sv
src/mct_ring.sv
src/majority_commit_tracker.sv
sim/tb_top.sv
